/* rtl/deq_pkg.sv */
// Shared constants, codes and interface structs of the double-ended queue.
package deq_pkg;

   localparam int DEPTH      = 64;
   localparam int WORD_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = 7;
   localparam int VALUE_W    = 32;

   typedef enum logic [1:0] {
      REQ_PUSH_FRONT = 2'd0,
      REQ_PUSH_REAR  = 2'd1,
      REQ_POP_FRONT  = 2'd2,
      REQ_POP_REAR   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic                  we;
      logic [IDX_W-1:0]      addr;
      logic [WORD_WIDTH-1:0] wdata;
   } ram_cmd_type;

   typedef struct packed {
      logic             valid;
      logic             pop_ok;
      status_type       status;
      logic [CNT_W-1:0] count;
   } rsp_info_type;

endpackage

/* rtl/deq_ram.sv */
// Generic single-port RAM with registered read data.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/deq_ctrl.sv */
// Pointer and count control: decodes a request into one RAM access and a result.
module deq_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [1:0]                     req_type,
   input  logic [deq_pkg::WORD_WIDTH-1:0] push_word,
   output deq_pkg::ram_cmd_type           ram_cmd,
   output deq_pkg::rsp_info_type          rsp_info
);

   logic [deq_pkg::IDX_W-1:0] front_ff, front_in;
   logic [deq_pkg::IDX_W-1:0] rear_ff, rear_in;
   logic [deq_pkg::CNT_W-1:0] count_ff, count_in;
   deq_pkg::rsp_info_type     info_ff, info_in;

   logic [deq_pkg::IDX_W-1:0] front_dec, front_inc, rear_dec, rear_inc;
   logic                      full, empty;
   deq_pkg::req_code_type     code;

   assign code      = deq_pkg::req_code_type'(req_type);
   assign full      = (count_ff == deq_pkg::CNT_W'(deq_pkg::DEPTH));
   assign empty     = (count_ff == '0);
   assign front_inc = (front_ff == deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? deq_pkg::IDX_W'(deq_pkg::DEPTH - 1) : front_ff - 1'b1;
   assign rear_inc  = (rear_ff == deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)) ? '0 : rear_ff + 1'b1;
   assign rear_dec  = (rear_ff == '0) ? deq_pkg::IDX_W'(deq_pkg::DEPTH - 1) : rear_ff - 1'b1;

   always_comb begin
      front_in       = front_ff;
      rear_in        = rear_ff;
      count_in       = count_ff;
      ram_cmd.we     = 1'b0;
      ram_cmd.addr   = front_ff;
      ram_cmd.wdata  = push_word;
      info_in.valid  = accept;
      info_in.pop_ok = 1'b0;
      info_in.status = deq_pkg::ST_DONE;
      if (accept) begin
         case (code)
            deq_pkg::REQ_PUSH_FRONT: begin
               if (full) begin
                  info_in.status = deq_pkg::ST_FULL;
               end else begin
                  front_in     = front_dec;
                  ram_cmd.we   = 1'b1;
                  ram_cmd.addr = front_dec;
                  count_in     = count_ff + 1'b1;
               end
            end
            deq_pkg::REQ_PUSH_REAR: begin
               if (full) begin
                  info_in.status = deq_pkg::ST_FULL;
               end else begin
                  rear_in      = rear_inc;
                  ram_cmd.we   = 1'b1;
                  ram_cmd.addr = rear_ff;
                  count_in     = count_ff + 1'b1;
               end
            end
            deq_pkg::REQ_POP_FRONT: begin
               if (empty) begin
                  info_in.status = deq_pkg::ST_EMPTY;
               end else begin
                  front_in       = front_inc;
                  ram_cmd.addr   = front_ff;
                  info_in.pop_ok = 1'b1;
                  count_in       = count_ff - 1'b1;
               end
            end
            deq_pkg::REQ_POP_REAR: begin
               if (empty) begin
                  info_in.status = deq_pkg::ST_EMPTY;
               end else begin
                  rear_in        = rear_dec;
                  ram_cmd.addr   = rear_dec;
                  info_in.pop_ok = 1'b1;
                  count_in       = count_ff - 1'b1;
               end
            end
            default: begin
               info_in.status = deq_pkg::ST_DONE;
            end
         endcase
      end
      info_in.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         rear_ff       <= '0;
         count_ff      <= '0;
         info_ff.valid <= 1'b0;
      end else begin
         front_ff      <= front_in;
         rear_ff       <= rear_in;
         count_ff      <= count_in;
         info_ff.valid <= info_in.valid;
      end
      info_ff.pop_ok <= info_in.pop_ok;
      info_ff.status <= info_in.status;
      info_ff.count  <= info_in.count;
   end

   assign rsp_info = info_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
      else $error("stored count beyond depth");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept && !reset |=> info_ff.valid)
      else $error("accepted item gave no result");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      info_ff.valid && info_ff.status == deq_pkg::ST_FULL
         |-> info_ff.count == deq_pkg::CNT_W'(deq_pkg::DEPTH))
      else $error("full reported below depth");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      info_ff.valid && info_ff.status == deq_pkg::ST_EMPTY |-> info_ff.count == '0)
      else $error("empty reported with stored words");

endmodule

/* rtl/double_ended_queue_core.sv */
// Top level of the double-ended queue: request decode, word RAM and result drive.
//
// Bounded deque of signed words kept in a ring buffer of deq_pkg::DEPTH slots.
// Request channel: start with req_type (0 push front, 1 push rear, 2 pop front,
// 3 pop rear) and req_push_value; an item is taken at a clock edge where start
// is high and busy is low. busy stays low: every request is a single RAM
// access, so one item can be taken in every cycle.
// Result channel: rsp_valid is high for exactly one cycle, in the cycle after the
// item was taken, carrying rsp_pop_value, rsp_status and rsp_entry_count.
// The popped word comes from the registered read port of the word RAM; a pop
// right after a push sees the pushed word since the write lands first.
// Throughput is one item per cycle.
// A push when full or a pop when empty leaves the queue unchanged and returns
// status full or empty with a zero word.
// Synchronous reset empties the queue (pointers and count to zero); the RAM
// contents are not cleared. The receiver cannot stall: results must be taken
// in the cycle they are shown.
module double_ended_queue_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_type,
   input  logic signed [31:0]          req_push_value,
   output logic                        rsp_valid,
   output logic signed [31:0]          rsp_pop_value,
   output logic [1:0]                  rsp_status,
   output logic [deq_pkg::CNT_W-1:0]   rsp_entry_count
);

   deq_pkg::ram_cmd_type             ram_cmd;
   deq_pkg::rsp_info_type            rsp_info;
   logic [deq_pkg::WORD_WIDTH-1:0]   rd_word;
   logic                             accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_type  (req_type),
      .push_word (deq_pkg::WORD_WIDTH'(req_push_value)),
      .ram_cmd   (ram_cmd),
      .rsp_info  (rsp_info)
   );

   deq_ram #(
      .WIDTH (deq_pkg::WORD_WIDTH),
      .DEPTH (deq_pkg::DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_cmd.we),
      .addr  (ram_cmd.addr),
      .wdata (ram_cmd.wdata),
      .rdata (rd_word)
   );

   assign rsp_valid       = rsp_info.valid;
   assign rsp_pop_value   = rsp_info.pop_ok ? deq_pkg::VALUE_W'(signed'(rd_word)) : '0;
   assign rsp_status      = rsp_info.status;
   assign rsp_entry_count = rsp_info.count;

endmodule

/* dv/double_ended_queue_core_tb.sv */
`timescale 1ns / 100ps
// Testbench of the double-ended queue core: push/pop traffic checked against a deque predictor.
module double_ended_queue_core_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS  = 200;

   typedef struct {
      logic                  drain;
      deq_pkg::req_code_type op;
      logic signed [31:0]    value;
      int unsigned           gap_pct;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0]        pop_value;
      deq_pkg::status_type       status;
      logic [deq_pkg::CNT_W-1:0] count;
   } deque_rsp_type;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          start          = 1'b0;
   logic                          busy;
   logic [1:0]                    req_type       = deq_pkg::REQ_PUSH_FRONT;
   logic signed [31:0]            req_push_value = '0;
   logic                          rsp_valid;
   logic signed [31:0]            rsp_pop_value;
   logic [1:0]                    rsp_status;
   logic [deq_pkg::CNT_W-1:0]     rsp_entry_count;

   req_item_type                  pending_items[$];
   deque_rsp_type                 expected_rsps[$];
   int unsigned                   mismatches = 0;
   int unsigned                   cycles     = 0;

   // predictor copy of the ring buffer
   logic [deq_pkg::WORD_WIDTH-1:0] slot_words[deq_pkg::DEPTH];
   logic [deq_pkg::IDX_W-1:0]      head_idx   = '0;
   logic [deq_pkg::IDX_W-1:0]      tail_idx   = '0;
   logic [deq_pkg::CNT_W-1:0]      fill_level = '0;

   double_ended_queue_core u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_pop_value   (rsp_pop_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   always #1 clock = ~clock;

   function automatic logic [deq_pkg::IDX_W-1:0] idx_inc(logic [deq_pkg::IDX_W-1:0] idx);
      return (idx == deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [deq_pkg::IDX_W-1:0] idx_dec(logic [deq_pkg::IDX_W-1:0] idx);
      return (idx == '0) ? deq_pkg::IDX_W'(deq_pkg::DEPTH - 1) : idx - 1'b1;
   endfunction

   // applies one request to the predictor state and returns the result it gives
   function automatic deque_rsp_type deque_apply(deq_pkg::req_code_type op,
                                                 logic signed [31:0] value);
      deque_rsp_type r;
      r.pop_value = '0;
      r.status    = deq_pkg::ST_DONE;
      if (op == deq_pkg::REQ_PUSH_FRONT || op == deq_pkg::REQ_PUSH_REAR) begin
         if (fill_level == deq_pkg::CNT_W'(deq_pkg::DEPTH)) begin
            r.status = deq_pkg::ST_FULL;
         end else if (op == deq_pkg::REQ_PUSH_FRONT) begin
            head_idx = idx_dec(head_idx);
            slot_words[head_idx] = value;
            fill_level++;
         end else begin
            slot_words[tail_idx] = value;
            tail_idx = idx_inc(tail_idx);
            fill_level++;
         end
      end else begin
         if (fill_level == '0) begin
            r.status = deq_pkg::ST_EMPTY;
         end else if (op == deq_pkg::REQ_POP_FRONT) begin
            r.pop_value = slot_words[head_idx];
            head_idx = idx_inc(head_idx);
            fill_level--;
         end else begin
            tail_idx = idx_dec(tail_idx);
            r.pop_value = slot_words[tail_idx];
            fill_level--;
         end
      end
      r.count = fill_level;
      return r;
   endfunction

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return '1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic deq_pkg::req_code_type pick_op(int unsigned push_pct);
      if ($urandom_range(99) < push_pct) begin
         if ($urandom_range(1) != 0) return deq_pkg::REQ_PUSH_REAR;
         return deq_pkg::REQ_PUSH_FRONT;
      end
      if ($urandom_range(1) != 0) return deq_pkg::REQ_POP_REAR;
      return deq_pkg::REQ_POP_FRONT;
   endfunction

   task automatic queue_item(deq_pkg::req_code_type op, logic signed [31:0] value,
                             int unsigned gap);
      req_item_type it;
      it.drain   = 1'b0;
      it.op      = op;
      it.value   = value;
      it.gap_pct = gap;
      pending_items.push_back(it);
   endtask

   // marker: sender holds off until every outstanding result is back
   task automatic queue_drain();
      req_item_type it;
      it.drain   = 1'b1;
      it.op      = deq_pkg::REQ_POP_FRONT;
      it.value   = '0;
      it.gap_pct = 0;
      pending_items.push_back(it);
   endtask

   always @(posedge clock) begin : driver
      req_item_type it;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (pending_items.size() != 0 && pending_items[0].drain && !start &&
             expected_rsps.size() == 0)
            void'(pending_items.pop_front());
         if (pending_items.size() != 0 && !pending_items[0].drain &&
             $urandom_range(99) >= pending_items[0].gap_pct) begin
            it = pending_items.pop_front();
            start          <= 1'b1;
            req_type       <= it.op;
            req_push_value <= it.value;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      deque_rsp_type want;
      if (!reset) begin
         if (start && !busy)
            expected_rsps.push_back(deque_apply(deq_pkg::req_code_type'(req_type),
                                                req_push_value));
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: pop_value %0d status %0d count %0d",
                           rsp_pop_value, rsp_status, rsp_entry_count);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_pop_value !== want.pop_value || rsp_status !== want.status ||
                   rsp_entry_count !== want.count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected pop_value %0d status %0d count %0d,",
                               " got pop_value %0d status %0d count %0d"},
                              want.pop_value, want.status, want.count,
                              rsp_pop_value, rsp_status, rsp_entry_count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned gaps[3];
      int unsigned placed;
      int unsigned seg_len;
      int unsigned push_pct;
      gaps = '{14, 55, 0};

      // directed: empty pops, extreme words, last-word pops from each end
      queue_item(deq_pkg::REQ_POP_FRONT,  '0, 14);
      queue_item(deq_pkg::REQ_POP_REAR,   '0, 14);
      queue_item(deq_pkg::REQ_PUSH_FRONT, 32'sh7fffffff, 14);
      queue_item(deq_pkg::REQ_PUSH_REAR,  32'sh80000000, 14);
      queue_item(deq_pkg::REQ_PUSH_FRONT, '1, 14);
      queue_item(deq_pkg::REQ_PUSH_REAR,  '0, 14);
      queue_item(deq_pkg::REQ_POP_FRONT,  32'sh12345678, 14);
      queue_item(deq_pkg::REQ_POP_REAR,   '0, 14);
      queue_item(deq_pkg::REQ_POP_REAR,   '0, 14);
      queue_item(deq_pkg::REQ_POP_FRONT,  '0, 14);
      queue_item(deq_pkg::REQ_POP_FRONT,  '0, 14);
      queue_item(deq_pkg::REQ_PUSH_FRONT, 32'sh55555555, 14);
      queue_item(deq_pkg::REQ_POP_REAR,   '0, 14);
      queue_item(deq_pkg::REQ_PUSH_REAR,  32'shaaaaaaaa, 14);
      queue_item(deq_pkg::REQ_POP_FRONT,  '0, 14);
      queue_item(deq_pkg::REQ_POP_REAR,   '0, 14);
      queue_item(deq_pkg::REQ_PUSH_REAR,  32'sd1, 14);
      queue_item(deq_pkg::REQ_PUSH_FRONT, 32'sd2, 14);
      queue_item(deq_pkg::REQ_POP_REAR,   '0, 14);
      queue_item(deq_pkg::REQ_POP_REAR,   '0, 14);
      queue_drain();

      // fill to capacity from random ends, then overflow on both ends
      for (int i = 0; i < deq_pkg::DEPTH; i++)
         queue_item(pick_op(100), pick_word(), 14);
      queue_item(deq_pkg::REQ_PUSH_FRONT, pick_word(), 14);
      queue_item(deq_pkg::REQ_PUSH_REAR,  pick_word(), 14);
      queue_drain();

      // biased segments swing the fill level between empty and full
      foreach (gaps[p]) begin
         placed = 0;
         while (placed < PHASE_ITEMS) begin
            seg_len = $urandom_range(80, 20);
            case ($urandom_range(2))
               0: push_pct = 85;
               1: push_pct = 15;
               default: push_pct = 50;
            endcase
            if ($urandom_range(3) == 0)
               queue_drain();
            for (int i = 0; i < seg_len; i++)
               queue_item(pick_op(push_pct), pick_word(), gaps[p]);
            placed += seg_len;
         end
         queue_drain();
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_items.size() != 0 || start || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue_core.sv
dv/double_ended_queue_core_tb.sv
